// File: design/csfft_pkg.sv
package csfft_pkg;

    localparam int DATA_W   = 40;
    localparam int SAMPLE_W = 32;
    localparam int CHUNK    = 64;
    localparam int CHUNK_W  = 7;

    localparam logic [1:0] MODE_INV_SCALED = 2'd1;
    localparam logic [1:0] MODE_INV_RAW    = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_SLOTS = 1'b1;

    localparam logic [63:0] PI4_Q63 = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q63 = 64'h8000000000000000;

    localparam logic signed [DATA_W-1:0] MAX40 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN40 = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        WR_SAMPLE,
        WR_BF_A,
        WR_BF_B,
        WR_SWAP_A,
        WR_SWAP_B
    } wr_sel_t;

    typedef struct packed {
        logic    rd_en;
        logic    pre_en;
        logic    mul_en;
        logic    cmb_en;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    out_ld;
        logic    out_last;
        logic    inverse;
        logic    scale;
    } cmd_t;

    function automatic logic [63:0] mul63(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    // cos and sin of (pi/4)*r/2^l in Q63, returned as {cos, sin}
    function automatic logic [127:0] octant_cs(input logic [63:0] r, input int unsigned l);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] ss;
        logic [63:0] tc;
        logic [63:0] sc;
        x  = mul63(PI4_Q63, r << (63 - l));
        x2 = mul63(x, x);
        ts = x;
        ss = x;
        tc = ONE_Q63;
        sc = ONE_Q63;
        ts = mul63(ts, x2) / 64'd6;   tc = mul63(tc, x2) / 64'd2;   ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd20;  tc = mul63(tc, x2) / 64'd12;  ss = ss + ts; sc = sc + tc;
        ts = mul63(ts, x2) / 64'd42;  tc = mul63(tc, x2) / 64'd30;  ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd72;  tc = mul63(tc, x2) / 64'd56;  ss = ss + ts; sc = sc + tc;
        ts = mul63(ts, x2) / 64'd110; tc = mul63(tc, x2) / 64'd90;  ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd156; tc = mul63(tc, x2) / 64'd132; ss = ss + ts; sc = sc + tc;
        ts = mul63(ts, x2) / 64'd210; tc = mul63(tc, x2) / 64'd182; ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd272; tc = mul63(tc, x2) / 64'd240; ss = ss + ts; sc = sc + tc;
        ts = mul63(ts, x2) / 64'd342; tc = mul63(tc, x2) / 64'd306; ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd420; tc = mul63(tc, x2) / 64'd380; ss = ss + ts; sc = sc + tc;
        ts = mul63(ts, x2) / 64'd506; tc = mul63(tc, x2) / 64'd462; ss = ss - ts; sc = sc - tc;
        ts = mul63(ts, x2) / 64'd600; tc = mul63(tc, x2) / 64'd552; ss = ss + ts; sc = sc + tc;
        return {sc, ss};
    endfunction

    function automatic logic [63:0] round_tw(input logic [63:0] v, input int unsigned f);
        return (v + (64'd1 << (62 - f))) >> (63 - f);
    endfunction

    // twiddle entry j as {re[31:0], im[31:0]}, Q1.f, sign extended
    function automatic logic [63:0] tw_entry(input int unsigned j, input int unsigned l,
                                             input int unsigned f);
        logic [63:0]  m;
        logic [63:0]  t;
        logic [63:0]  oct;
        logic [63:0]  r;
        logic [127:0] cs;
        logic [63:0]  cb;
        logic [63:0]  sb;
        logic [63:0]  wr;
        logic [63:0]  wi;
        m   = 64'd1 << l;
        t   = (64'(j) & (m - 64'd1)) * 64'd8;
        oct = t >> l;
        r   = t & (m - 64'd1);
        if (oct[0])
        begin
            cs = octant_cs(m - r, l);
            cb = round_tw(cs[63:0], f);
            sb = round_tw(cs[127:64], f);
        end
        else
        begin
            cs = octant_cs(r, l);
            cb = round_tw(cs[127:64], f);
            sb = round_tw(cs[63:0], f);
        end
        case (oct[2:1])
            2'd0:
            begin
                wr = cb;
                wi = sb;
            end
            2'd1:
            begin
                wr = -sb;
                wi = cb;
            end
            2'd2:
            begin
                wr = -cb;
                wi = -sb;
            end
            default:
            begin
                wr = sb;
                wi = -cb;
            end
        endcase
        return {wr[31:0], wi[31:0]};
    endfunction

endpackage

// File: design/csfft_dp.sv
module csfft_dp
    import csfft_pkg::*;
#(
    parameter int AW     = 9,
    parameter int RING_W = 11,
    parameter int TW_W   = 18,
    parameter int FRAC_W = 16
)
(
    input  logic                       clk,
    input  cmd_t                       cmd,
    input  logic [AW-1:0]              rd_addr_a,
    input  logic [AW-1:0]              rd_addr_b,
    input  logic [AW-1:0]              wr_addr,
    input  logic [RING_W-1:0]          tw_idx,
    input  logic [3:0]                 k,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    output logic signed [SAMPLE_W-1:0] result_re,
    output logic signed [SAMPLE_W-1:0] result_im,
    output logic                       last_result
);

    localparam int DEPTH = 1 << AW;
    localparam int M     = 1 << RING_W;
    localparam int MW    = DATA_W + TW_W;
    localparam int PW    = DATA_W + TW_W + 2;

    localparam logic signed [PW-1:0] P_MAX = {{(PW-DATA_W){1'b0}}, MAX40};
    localparam logic signed [PW-1:0] P_MIN = {{(PW-DATA_W){1'b1}}, MIN40};
    localparam logic signed [PW-1:0] P_RND = PW'(1) << (FRAC_W - 1);

    function automatic logic signed [DATA_W-1:0] sat_p(input logic signed [PW-1:0] v);
        if (v > P_MAX)
            return MAX40;
        else if (v < P_MIN)
            return MIN40;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat40(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
            return v[DATA_W] ? MIN40 : MAX40;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [DATA_W:0] v);
        if (v > (DATA_W+1)'(signed'(33'sh0_7FFF_FFFF)))
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (v < -(DATA_W+1)'(signed'(33'sh0_8000_0000)))
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return v[SAMPLE_W-1:0];
    endfunction

    logic [2*DATA_W-1:0] mem [DEPTH];
    logic [2*TW_W-1:0]   tw_rom [M];

    for (genvar g = 0; g < M; g++)
    begin : g_rom
        localparam logic [63:0] ENT = tw_entry(g, RING_W, FRAC_W);
        assign tw_rom[g] = {ENT[32+TW_W-1:32], ENT[TW_W-1:0]};
    end

    logic [2*DATA_W-1:0]       rd_a_reg;
    logic [2*DATA_W-1:0]       rd_b_reg;
    logic [2*TW_W-1:0]         tw_reg;
    logic signed [DATA_W-1:0]  x_re_reg, x_im_reg, v_re_reg, v_im_reg;
    logic signed [DATA_W-1:0]  p_re_reg, p_im_reg;
    logic signed [MW-1:0]      m_rr_reg, m_ii_reg, m_ri_reg, m_ir_reg;
    logic signed [SAMPLE_W-1:0] res_re_reg, res_im_reg;
    logic                      last_reg;

    logic signed [DATA_W-1:0]  a_re, a_im, b_re, b_im;
    logic signed [TW_W-1:0]    w_re, w_im;
    logic signed [PW-1:0]      d_re, d_im;
    logic [2*DATA_W-1:0]       wdata;
    logic signed [DATA_W:0]    sc_re, sc_im, rnd_k;

    assign a_re = rd_a_reg[2*DATA_W-1:DATA_W];
    assign a_im = rd_a_reg[DATA_W-1:0];
    assign b_re = rd_b_reg[2*DATA_W-1:DATA_W];
    assign b_im = rd_b_reg[DATA_W-1:0];
    assign w_re = tw_reg[2*TW_W-1:TW_W];
    assign w_im = tw_reg[TW_W-1:0];

    assign d_re = (PW'(m_rr_reg) - PW'(m_ii_reg) + P_RND) >>> FRAC_W;
    assign d_im = (PW'(m_ri_reg) + PW'(m_ir_reg) + P_RND) >>> FRAC_W;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SAMPLE:
                wdata = {{(DATA_W-SAMPLE_W){sample_re[SAMPLE_W-1]}}, sample_re,
                         {(DATA_W-SAMPLE_W){sample_im[SAMPLE_W-1]}}, sample_im};
            WR_BF_A:
                if (cmd.inverse)
                    wdata = {x_re_reg, x_im_reg};
                else
                    wdata = {sat40({x_re_reg[DATA_W-1], x_re_reg} + {p_re_reg[DATA_W-1], p_re_reg}),
                             sat40({x_im_reg[DATA_W-1], x_im_reg} + {p_im_reg[DATA_W-1], p_im_reg})};
            WR_BF_B:
                if (cmd.inverse)
                    wdata = {p_re_reg, p_im_reg};
                else
                    wdata = {sat40({x_re_reg[DATA_W-1], x_re_reg} - {p_re_reg[DATA_W-1], p_re_reg}),
                             sat40({x_im_reg[DATA_W-1], x_im_reg} - {p_im_reg[DATA_W-1], p_im_reg})};
            WR_SWAP_A:
                wdata = rd_b_reg;
            WR_SWAP_B:
                wdata = rd_a_reg;
            default:
                wdata = rd_a_reg;
        endcase
    end

    // round half up, then shift by log2 n
    always_comb
    begin
        rnd_k = (DATA_W+1)'(1) << (k - 4'd1);
        if (cmd.scale)
        begin
            sc_re = ($signed({a_re[DATA_W-1], a_re}) + rnd_k) >>> k;
            sc_im = ($signed({a_im[DATA_W-1], a_im}) + rnd_k) >>> k;
        end
        else
        begin
            sc_re = {a_re[DATA_W-1], a_re};
            sc_im = {a_im[DATA_W-1], a_im};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wdata;
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
            tw_reg   <= tw_rom[tw_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pre_en)
        begin
            if (cmd.inverse)
            begin
                x_re_reg <= sat40({a_re[DATA_W-1], a_re} + {b_re[DATA_W-1], b_re});
                x_im_reg <= sat40({a_im[DATA_W-1], a_im} + {b_im[DATA_W-1], b_im});
                v_re_reg <= sat40({a_re[DATA_W-1], a_re} - {b_re[DATA_W-1], b_re});
                v_im_reg <= sat40({a_im[DATA_W-1], a_im} - {b_im[DATA_W-1], b_im});
            end
            else
            begin
                x_re_reg <= a_re;
                x_im_reg <= a_im;
                v_re_reg <= b_re;
                v_im_reg <= b_im;
            end
        end
        if (cmd.mul_en)
        begin
            m_rr_reg <= v_re_reg * w_re;
            m_ii_reg <= v_im_reg * w_im;
            m_ri_reg <= v_re_reg * w_im;
            m_ir_reg <= v_im_reg * w_re;
        end
        if (cmd.cmb_en)
        begin
            p_re_reg <= sat_p(d_re);
            p_im_reg <= sat_p(d_im);
        end
        if (cmd.out_ld)
        begin
            res_re_reg <= sat32(sc_re);
            res_im_reg <= sat32(sc_im);
            last_reg   <= cmd.out_last;
        end
    end

    assign result_re   = res_re_reg;
    assign result_im   = res_im_reg;
    assign last_result = last_reg;

endmodule

// File: design/csfft_ctrl.sv
module csfft_ctrl
    import csfft_pkg::*;
#(
    parameter int AW     = 9,
    parameter int RING_W = 11,
    parameter int KMAX   = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output cmd_t              cmd,
    output logic [AW-1:0]     rd_addr_a,
    output logic [AW-1:0]     rd_addr_b,
    output logic [AW-1:0]     wr_addr,
    output logic [RING_W-1:0] tw_idx,
    output logic [3:0]        k
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_BR_RD,
        S_BR_WA,
        S_BR_WB,
        S_BF_RD,
        S_BF_PRE,
        S_BF_MUL,
        S_BF_CMB,
        S_BF_WA,
        S_BF_WB,
        S_EM_RD,
        S_EM_LD,
        S_EM_WAIT
    } state_t;

    function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] v, input logic [3:0] kk);
        logic [AW-1:0] r;
        for (int i = 0; i < AW; i++)
            r[i] = v[AW-1-i];
        return r >> (4'(AW) - kk);
    endfunction

    state_t              state_reg, state_next;
    logic [1:0]          mode_reg;
    logic [3:0]          slots_reg;
    logic [AW:0]         lc_reg, lc_next;
    logic [3:0]          k_reg, k_next;
    logic                inv_reg, inv_next;
    logic                scale_reg, scale_next;
    logic                pend_reg, pend_next;
    logic [AW:0]         cnt_reg, cnt_next;
    logic [3:0]          s_reg, s_next;
    logic [RING_W-1:0]   p5_reg, p5_next;
    logic [CHUNK_W-1:0]  cc_reg, cc_next;

    logic [3:0]          k_cur;
    logic [AW:0]         n_cur, n_lat, lc_eff;
    logic [AW-1:0]       idx, idx_rev, hm, half, bf_a, bf_b, j_nxt;
    logic [4:0]          s2;
    logic [RING_W:0]     q4, pm, tw_val;
    logic                inv_cur, stage_last;

    assign k_cur   = (slots_reg > 4'(KMAX)) ? 4'(KMAX) : slots_reg;
    assign n_cur   = (AW+1)'(1) << k_cur;
    assign n_lat   = (AW+1)'(1) << k_reg;
    assign lc_eff  = (lc_reg >= n_cur) ? '0 : lc_reg;
    assign inv_cur = (mode_reg == MODE_INV_SCALED) || (mode_reg == MODE_INV_RAW);

    assign idx     = cnt_reg[AW-1:0];
    assign idx_rev = rev_bits(idx, k_reg);
    assign half    = AW'(1) << (s_reg - 4'd1);
    assign hm      = half - AW'(1);
    assign bf_a    = ((idx & ~hm) << 1) | (idx & hm);
    assign bf_b    = bf_a | half;
    assign j_nxt   = (idx + AW'(1)) & hm;

    // twiddle index: (5^j mod 4len) scaled to the ring, conjugated when inverse
    assign s2      = {1'b0, s_reg} + 5'd2;
    assign q4      = (RING_W+1)'(1) << s2;
    assign pm      = {1'b0, p5_reg} & (q4 - (RING_W+1)'(1));
    assign tw_val  = (inv_reg ? (q4 - pm) : pm) << (5'(RING_W) - s2);
    assign tw_idx  = tw_val[RING_W-1:0];

    assign stage_last = inv_reg ? (s_reg == 4'd1) : (s_reg == k_reg);

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = (state_reg == S_EM_WAIT);
    assign k         = k_reg;

    always_comb
    begin
        state_next = state_reg;
        lc_next    = lc_reg;
        k_next     = k_reg;
        inv_next   = inv_reg;
        scale_next = scale_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        p5_next    = p5_reg;
        cc_next    = cc_reg;
        cmd        = '0;
        cmd.inverse  = inv_reg;
        cmd.scale    = scale_reg;
        cmd.wr_sel   = WR_SAMPLE;
        cmd.out_last = (cnt_reg == n_lat - (AW+1)'(1));
        rd_addr_a  = idx;
        rd_addr_b  = idx_rev;
        wr_addr    = idx;

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (pend_reg)
                        state_next = S_EM_RD;
                    else
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_SAMPLE;
                        wr_addr    = lc_eff[AW-1:0];
                        if (lc_eff + (AW+1)'(1) == n_cur)
                        begin
                            lc_next    = '0;
                            k_next     = k_cur;
                            inv_next   = inv_cur;
                            scale_next = (mode_reg == MODE_INV_SCALED) && (k_cur != 4'd0);
                            cnt_next   = '0;
                            cc_next    = '0;
                            p5_next    = RING_W'(1);
                            s_next     = inv_cur ? k_cur : 4'd1;
                            if (k_cur == 4'd0)
                                state_next = S_EM_RD;
                            else if (inv_cur)
                                state_next = S_BF_RD;
                            else
                                state_next = S_BR_RD;
                        end
                        else
                            lc_next = lc_eff + (AW+1)'(1);
                    end
                end
            end
            S_BR_RD:
            begin
                if (idx < idx_rev)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_BR_WA;
                end
                else if (cnt_reg == n_lat - (AW+1)'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_BF_RD;
                end
                else
                    cnt_next = cnt_reg + (AW+1)'(1);
            end
            S_BR_WA:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SWAP_A;
                wr_addr    = idx;
                state_next = S_BR_WB;
            end
            S_BR_WB:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SWAP_B;
                wr_addr    = idx_rev;
                if (cnt_reg == n_lat - (AW+1)'(1))
                begin
                    cnt_next   = '0;
                    state_next = S_BF_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + (AW+1)'(1);
                    state_next = S_BR_RD;
                end
            end
            S_BF_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr_a  = bf_a;
                rd_addr_b  = bf_b;
                state_next = S_BF_PRE;
            end
            S_BF_PRE:
            begin
                cmd.pre_en = 1'b1;
                state_next = S_BF_MUL;
            end
            S_BF_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_BF_CMB;
            end
            S_BF_CMB:
            begin
                cmd.cmb_en = 1'b1;
                state_next = S_BF_WA;
            end
            S_BF_WA:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_BF_A;
                wr_addr    = bf_a;
                state_next = S_BF_WB;
            end
            S_BF_WB:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_BF_B;
                wr_addr    = bf_b;
                if (cnt_reg == (n_lat >> 1) - (AW+1)'(1))
                begin
                    cnt_next = '0;
                    p5_next  = RING_W'(1);
                    if (stage_last)
                    begin
                        cc_next    = '0;
                        state_next = S_EM_RD;
                    end
                    else
                    begin
                        s_next     = inv_reg ? s_reg - 4'd1 : s_reg + 4'd1;
                        state_next = S_BF_RD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + (AW+1)'(1);
                    p5_next    = (j_nxt == '0) ? RING_W'(1) : RING_W'(p5_reg + (p5_reg << 2));
                    state_next = S_BF_RD;
                end
            end
            S_EM_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr_a  = inv_reg ? idx_rev : idx;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                cmd.out_ld = 1'b1;
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (!out_stall)
                begin
                    if (cnt_reg == n_lat - (AW+1)'(1))
                    begin
                        cnt_next   = '0;
                        cc_next    = '0;
                        pend_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else if (cc_reg == CHUNK_W'(CHUNK - 1))
                    begin
                        // hold the rest until the next request arrives
                        cnt_next   = cnt_reg + (AW+1)'(1);
                        cc_next    = '0;
                        pend_next  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + (AW+1)'(1);
                        cc_next    = cc_reg + CHUNK_W'(1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            mode_reg  <= '0;
            slots_reg <= '0;
            lc_reg    <= '0;
            k_reg     <= '0;
            inv_reg   <= 1'b0;
            scale_reg <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            s_reg     <= '0;
            p5_reg    <= RING_W'(1);
            cc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            k_reg     <= k_next;
            inv_reg   <= inv_next;
            scale_reg <= scale_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            s_reg     <= s_next;
            p5_reg    <= p5_next;
            cc_reg    <= cc_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_data[1:0];
                    REG_SLOTS: slots_reg <= cfg_data;
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("result offered while taking requests");

    a_pend_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && pend_reg) |-> (cnt_reg != '0))
        else $error("pending emission with no results delivered");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BF_RD) |-> (s_reg != 4'd0 && s_reg <= k_reg))
        else $error("butterfly stage out of range");

    a_scale_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_LD && scale_reg) |-> (k_reg != 4'd0))
        else $error("scaling with zero shift");

endmodule

// File: design/ckks_special_fft.sv
// CKKS special FFT over 2^k complex Q11.20 samples, k from log_slots.
// Write transform_mode and log_slots on the cfg port while the block is idle.
// Input requests carry one sample each (sample_re/sample_im) and are taken
// when in_valid is high and in_stall low. After the n-th sample the block
// runs the transform in place and emits up to 64 results on the output
// channel (result_re/result_im, last_result on the final one). If more
// results remain, each further input request is dropped and releases the
// next group of up to 64 results.
// The forward transform first swaps index pairs into bit-reversed order;
// each butterfly then runs on the single butterfly unit (read, pre-add,
// multiply, round, two memory writes) before the next one starts; each
// result is read and loaded into the output register. A stalled result
// holds on the port and the block waits; in_stall stays high from the
// last sample until the group of results is delivered.
// Reset clears the control counters and registers; sample memory and
// datapath registers are not cleared.
module ckks_special_fft
    import csfft_pkg::*;
#(
    parameter int LOG_RING      = 10,
    parameter int MAX_SLOTS     = 512,
    parameter int TWIDDLE_WIDTH = 18
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [3:0]                 cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_re,
    input  logic signed [SAMPLE_W-1:0] sample_im,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] result_re,
    output logic signed [SAMPLE_W-1:0] result_im,
    output logic                       last_result
);

    localparam int RING_W = LOG_RING + 1;
    localparam int FRAC_W = TWIDDLE_WIDTH - 2;
    localparam int SLOG   = ($clog2(MAX_SLOTS + 1) - 1 > 15) ? 15 : $clog2(MAX_SLOTS + 1) - 1;
    localparam int KMAX   = (SLOG > RING_W - 2) ? RING_W - 2 : SLOG;
    localparam int AW     = KMAX;

    cmd_t              cmd;
    logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
    logic [RING_W-1:0] tw_idx;
    logic [3:0]        k;

    csfft_ctrl #(
        .AW     (AW),
        .RING_W (RING_W),
        .KMAX   (KMAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .tw_idx    (tw_idx),
        .k         (k)
    );

    csfft_dp #(
        .AW     (AW),
        .RING_W (RING_W),
        .TW_W   (TWIDDLE_WIDTH),
        .FRAC_W (FRAC_W)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .wr_addr     (wr_addr),
        .tw_idx      (tw_idx),
        .k           (k),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .result_re   (result_re),
        .result_im   (result_im),
        .last_result (last_result)
    );

endmodule
